// ===== src/lbg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, command codes, register indexes and pin tables for the LED bar graph driver.
// Used by lbg_frame, lbg_shifter and led_bar_graph_scan_driver. No dependencies.
package lbg_pkg;

   // Width of the shift register chain and of one frame.
   localparam int CHAIN_BITS = 32;

   // Command codes.
   localparam logic [2:0] FUNC_WRITE_RED    = 3'd0;
   localparam logic [2:0] FUNC_WRITE_YELLOW = 3'd1;
   localparam logic [2:0] FUNC_SET_POSITION = 3'd2;
   localparam logic [2:0] FUNC_FILL_RED     = 3'd3;
   localparam logic [2:0] FUNC_ONE_YELLOW   = 3'd4;
   localparam logic [2:0] FUNC_REFRESH      = 3'd5;

   // Register indexes, selected by address bit 2.
   localparam logic CSR_MODULE_TYPE  = 1'b0;
   localparam logic CSR_DISPLAY_MODE = 1'b1;

   // Module types.
   localparam logic MODULE_RED_YELLOW = 1'b0;
   localparam logic MODULE_RED        = 1'b1;

   // Logical frame layout.
   localparam int YELLOW_BASE  = 21;
   localparam int YELLOW_SLOTS = 10;
   localparam int MAX_COLS     = 10;
   localparam int RY_COLS      = 8;
   localparam int RY_GROUPS    = 13;
   localparam int R_COLS       = 10;
   localparam int R_GROUPS     = 10;
   localparam int RY_OFFSET    = 4;

   // Red bar vector padded so that any scan row can be windowed without a range check.
   localparam int PAD_BITS = RY_OFFSET + 16 * MAX_COLS;

   // Chain bit reached by each logical frame bit.
   localparam logic [4:0] PIN_RY [CHAIN_BITS] = '{
      5'd31, 5'd8,  5'd27, 5'd24, 5'd5,  5'd3,  5'd9,  5'd12,
      5'd0,  5'd1,  5'd4,  5'd7,  5'd11, 5'd13, 5'd15, 5'd19,
      5'd21, 5'd23, 5'd26, 5'd28, 5'd30, 5'd2,  5'd6,  5'd10,
      5'd14, 5'd17, 5'd20, 5'd22, 5'd25, 5'd29, 5'd18, 5'd16
   };
   localparam logic [4:0] PIN_R [CHAIN_BITS] = '{
      5'd9,  5'd5,  5'd25, 5'd20, 5'd1,  5'd2,  5'd29, 5'd13,
      5'd16, 5'd26, 5'd0,  5'd3,  5'd7,  5'd11, 5'd15, 5'd18,
      5'd21, 5'd24, 5'd27, 5'd30, 5'd4,  5'd4,  5'd4,  5'd4,
      5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4
   };

   // One command.
   typedef struct packed {
      logic [2:0]        func;
      logic signed [7:0] index;
      logic              value;
   } req_type;

   // One serial bit of a frame.
   typedef struct packed {
      logic serial_bit;
      logic latch;
   } rsp_type;

   // Routes logical frame bits to chain bits; a higher logical bit wins a shared pin.
   function automatic logic [CHAIN_BITS-1:0] remap_pins(
      input logic [CHAIN_BITS-1:0] logical,
      input logic                  module_type
   );
      logic [CHAIN_BITS-1:0] chain;
      chain = '0;
      for (int i = 0; i < CHAIN_BITS; i++) begin
         if (module_type == MODULE_RED) begin
            chain[PIN_R[i]] = logical[i];
         end else begin
            chain[PIN_RY[i]] = logical[i];
         end
      end
      return chain;
   endfunction

endpackage

// ===== src/lbg_frame.sv =====
`timescale 1ns / 1ps
// Builds one 32-bit chain frame from the bar state and the current scan group.
// Depends on lbg_pkg.
module lbg_frame #(
   parameter int RED_BARS    = 100,
   parameter int YELLOW_BARS = 10
) (
   input  logic                           module_type,
   input  logic                           display_mode,
   input  logic [RED_BARS-1:0]            red_bars,
   input  logic [YELLOW_BARS-1:0]         yellow_bars,
   input  logic [6:0]                     bar_position,
   input  logic [3:0]                     scan_group,
   output logic [lbg_pkg::CHAIN_BITS-1:0] chain
);
   import lbg_pkg::*;

   logic [PAD_BITS-1:0]   padded;
   logic [7:0]            row_base;
   logic [MAX_COLS-1:0]   window;
   logic [7:0]            position;
   logic [14:0]           div_product;
   logic [4:0]            single_row;
   logic [3:0]            single_col;
   logic [4:0]            active_row;
   logic [CHAIN_BITS-1:0] logical;

   // Red bars shifted up by the red-yellow offset, zero above the last bar.
   always_comb begin
      padded = '0;
      padded[RY_OFFSET +: RED_BARS] = red_bars;
   end

   // Start of the scanned row within the padded vector.
   always_comb begin
      if (module_type == MODULE_RED) begin
         row_base = 8'({scan_group, 3'b000}) + 8'({scan_group, 1'b0}) + 8'(RY_OFFSET);
      end else begin
         row_base = 8'({scan_group, 3'b000});
      end
      window = MAX_COLS'(padded >> row_base);
   end

   // Single bar row and column; red modules divide by 10 via a reciprocal multiply.
   always_comb begin
      if (module_type == MODULE_RED) begin
         position    = {1'b0, bar_position};
         div_product = 15'(position) * 15'd205;
         single_row  = {1'b0, div_product[14:11]};
         single_col  = 4'(position - 8'({single_row, 3'b000}) - 8'({single_row, 1'b0}));
      end else begin
         position    = 8'(bar_position) + 8'(RY_OFFSET);
         div_product = '0;
         single_row  = position[7:3];
         single_col  = {1'b0, position[2:0]};
      end
      active_row = display_mode ? {1'b0, scan_group} : single_row;
   end

   // Logical frame: anodes, active-low cathodes, yellow anodes.
   always_comb begin
      logical = '0;
      if (module_type == MODULE_RED) begin
         for (int i = 0; i < R_COLS; i++) begin
            logical[i] = display_mode ? window[i] : (single_col == 4'(i));
         end
         for (int i = 0; i < R_GROUPS; i++) begin
            logical[R_COLS + i] = (active_row != 5'(i));
         end
      end else begin
         for (int i = 0; i < RY_COLS; i++) begin
            logical[i] = display_mode ? window[i] : (single_col == 4'(i));
         end
         for (int i = 0; i < RY_GROUPS; i++) begin
            logical[RY_COLS + i] = (active_row != 5'(i));
         end
         for (int i = 0; i < YELLOW_BARS; i++) begin
            logical[YELLOW_BASE + i] = yellow_bars[i];
         end
      end
      chain = remap_pins(logical, module_type);
   end

endmodule

// ===== src/lbg_shifter.sv =====
`timescale 1ns / 1ps
// Holds one frame and sends it out one chain bit per transfer, bit 31 first.
// Depends on lbg_pkg.
module lbg_shifter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load_valid,
   input  logic [lbg_pkg::CHAIN_BITS-1:0] load_frame,
   output logic                           load_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output lbg_pkg::rsp_type               rsp_data
);
   import lbg_pkg::*;

   localparam int CNT_W = $clog2(CHAIN_BITS);

   logic [CHAIN_BITS-1:0] frame_ff, frame_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  last_bit;
   logic                  rsp_xfer;

   assign last_bit   = (count_ff == CNT_W'(CHAIN_BITS - 1));
   assign rsp_xfer   = busy_ff && !rsp_stall;
   assign load_ready = !busy_ff || (rsp_xfer && last_bit);

   assign rsp_valid           = busy_ff;
   assign rsp_data.serial_bit = frame_ff[CHAIN_BITS-1];
   assign rsp_data.latch      = last_bit;

   // A new frame takes over as soon as the last bit of the previous one is taken.
   always_comb begin
      frame_in = frame_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (load_valid && load_ready) begin
         frame_in = load_frame;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (rsp_xfer) begin
         frame_in = {frame_ff[CHAIN_BITS-2:0], 1'b0};
         count_in = count_ff + CNT_W'(1);
         busy_in  = !last_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
      frame_ff <= frame_in;
   end

endmodule

// ===== src/led_bar_graph_scan_driver.sv =====
`timescale 1ns / 1ps
// Top level of the LED bar graph scan driver: command register, bar state, config registers.
// Depends on lbg_pkg, lbg_frame and lbg_shifter.

// Commands are taken into a one-entry input register and applied from there. Bar writes,
// position updates, fills and yellow selects never stall the input and can follow back to
// back. A refresh tick builds its frame, in the cycle it is applied, from the state left by
// earlier commands and hands it to the output serializer, which sends 32 transfers, one per
// cycle while the output is not stalled, chain bit 31 first, with latch set on the last one.
// The serializer paces the ticks: the next frame is loaded in the same cycle its predecessor's
// last bit is taken. A tick that arrives while a frame is still going out waits in the input
// register and stalls the input until that frame's last bit is taken. The first bit of a
// tick is presented once the tick has passed through the input register and been loaded into
// the serializer's frame register. Reset clears the control, configuration and bar state;
// there is no clearing pass. The held command and the frame register are not reset.
module led_bar_graph_scan_driver #(
   parameter int RED_BARS    = 100,
   parameter int YELLOW_BARS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lbg_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lbg_pkg::rsp_type  rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import lbg_pkg::*;

   localparam int RED_IDX_W    = $clog2(RED_BARS);
   localparam int YELLOW_IDX_W = (YELLOW_BARS > 1) ? $clog2(YELLOW_BARS) : 1;

   logic                   module_type_ff;
   logic                   display_mode_ff;
   logic                   req_full_ff, req_full_in;
   req_type                req_hold_ff;
   logic [RED_BARS-1:0]    red_bars_ff, red_bars_in;
   logic [YELLOW_BARS-1:0] yellow_bars_ff, yellow_bars_in;
   logic [6:0]             bar_position_ff, bar_position_in;
   logic [3:0]             scan_group_ff, scan_group_in;
   logic                   csr_write;
   logic                   req_accept;
   logic                   is_refresh;
   logic                   advance;
   logic                   load_ready;
   logic [CHAIN_BITS-1:0]  frame;
   logic [4:0]             group_next;
   logic [4:0]             group_count;

   // Configuration port: writes complete in the access phase, no wait states.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         CSR_MODULE_TYPE:  csr_prdata[0] = module_type_ff;
         CSR_DISPLAY_MODE: csr_prdata[0] = display_mode_ff;
         default:          csr_prdata    = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         module_type_ff  <= MODULE_RED_YELLOW;
         display_mode_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_MODULE_TYPE:  module_type_ff  <= csr_pwdata[0];
            CSR_DISPLAY_MODE: display_mode_ff <= csr_pwdata[0];
            default:          module_type_ff  <= module_type_ff;
         endcase
      end
   end

   // Input register: a held command leaves when it is applied; a tick waits for the serializer.
   assign is_refresh  = (req_hold_ff.func == FUNC_REFRESH);
   assign advance     = req_full_ff && (!is_refresh || load_ready);
   assign req_stall   = req_full_ff && !advance;
   assign req_accept  = req_valid && !req_stall;
   assign req_full_in = req_accept || (req_full_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff <= 1'b0;
      end else begin
         req_full_ff <= req_full_in;
      end
      if (req_accept) begin
         req_hold_ff <= req_data;
      end
   end

   // Scan group advance, wrapping at the module's group count.
   assign group_count = (module_type_ff == MODULE_RED) ? 5'(R_GROUPS) : 5'(RY_GROUPS);
   assign group_next  = 5'(scan_group_ff) + 5'd1;

   // Bar state updates for the command being applied.
   always_comb begin
      red_bars_in     = red_bars_ff;
      yellow_bars_in  = yellow_bars_ff;
      bar_position_in = bar_position_ff;
      scan_group_in   = scan_group_ff;
      if (advance) begin
         priority case (req_hold_ff.func)
            FUNC_WRITE_RED: begin
               if (!req_hold_ff.index[7] && (req_hold_ff.index[6:0] < 7'(RED_BARS))) begin
                  red_bars_in[req_hold_ff.index[RED_IDX_W-1:0]] = req_hold_ff.value;
               end
            end
            FUNC_WRITE_YELLOW: begin
               if (!req_hold_ff.index[7] && (req_hold_ff.index[6:0] < 7'(YELLOW_BARS))) begin
                  yellow_bars_in[req_hold_ff.index[YELLOW_IDX_W-1:0]] = req_hold_ff.value;
               end
            end
            FUNC_SET_POSITION: begin
               bar_position_in = req_hold_ff.index[6:0];
            end
            FUNC_FILL_RED: begin
               for (int i = 0; i < RED_BARS; i++) begin
                  red_bars_in[i] = (req_hold_ff.index >= $signed(8'(i)));
               end
            end
            FUNC_ONE_YELLOW: begin
               for (int i = 0; i < YELLOW_BARS; i++) begin
                  yellow_bars_in[i] = (req_hold_ff.index == $signed(8'(i)));
               end
            end
            FUNC_REFRESH: begin
               scan_group_in = (group_next >= group_count) ? 4'd0 : group_next[3:0];
            end
            default: begin
               scan_group_in = scan_group_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_bars_ff     <= '0;
         yellow_bars_ff  <= '0;
         bar_position_ff <= '0;
         scan_group_ff   <= '0;
      end else begin
         red_bars_ff     <= red_bars_in;
         yellow_bars_ff  <= yellow_bars_in;
         bar_position_ff <= bar_position_in;
         scan_group_ff   <= scan_group_in;
      end
   end

   // Frame for a refresh tick, built from the state before the tick's own update.
   lbg_frame #(
      .RED_BARS    (RED_BARS),
      .YELLOW_BARS (YELLOW_BARS)
   ) u_frame (
      .module_type  (module_type_ff),
      .display_mode (display_mode_ff),
      .red_bars     (red_bars_ff),
      .yellow_bars  (yellow_bars_ff),
      .bar_position (bar_position_ff),
      .scan_group   (scan_group_ff),
      .chain        (frame)
   );

   // Serial output of the frame.
   lbg_shifter u_shifter (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_full_ff && is_refresh),
      .load_frame (frame),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
